### rtl/update_frame_receiver_crc_check_macros.svh
// Assertion macros used by the RTL checks in ufr_back
`ifndef UPDATE_FRAME_RECEIVER_CRC_CHECK_MACROS_SVH
`define UPDATE_FRAME_RECEIVER_CRC_CHECK_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define UFR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define UFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ufr_pkg.sv
package ufr_pkg;

   // default buffer size, fixed header size and default queue depth
   localparam int MAX_PAYLOAD_DEF = 1024;
   localparam int HEADER_BYTES    = 11;
   localparam int QUEUE_DEPTH_DEF = 2;

   // frame length thresholds
   localparam int SHORT_MAX  = 5;  // this many bytes or fewer cannot hold a header
   localparam int FINAL_MIN  = 8;  // a final marker needs this many bytes

   // CRC-16/Modbus
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // frame marks, first character in the top byte
   localparam logic [39:0] HEAD_MARK = "start";
   localparam logic [23:0] TAIL_MARK = "end";

   // error limit after reset
   localparam logic [3:0] ERR_LIMIT_RST = 4'd5;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HEADER = 3'd1,
      ST_CRC_BAD    = 3'd2,
      ST_SHORT      = 3'd3,
      ST_FINAL      = 3'd4,
      ST_TOO_LONG   = 3'd5
   } status_type;

   // classified frame handed from front to back
   typedef struct packed {
      status_type  status;
      logic [15:0] pkt_index;
      logic [15:0] crc;
   } frame_info_type;

   // one reflected CRC byte update, eight bit steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/ufr_if.sv
// request channel: received bytes
interface ufr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// response channel: one per frame
interface ufr_rsp_if #(parameter int LEN_W = 11);
   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic [15:0]      pkt_index;
   logic [LEN_W-1:0] payload_length;
   logic [15:0]      computed_crc;
   logic [15:0]      request_index;
   logic [15:0]      accepted_count;
   logic             final_complete;

   modport source (output valid, output status, output pkt_index, output payload_length,
                   output computed_crc, output request_index, output accepted_count,
                   output final_complete, input ready);
   modport sink   (input valid, input status, input pkt_index, input payload_length,
                   input computed_crc, input request_index, input accepted_count,
                   input final_complete, output ready);
endinterface

// register write channel
interface ufr_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] error_limit;

   modport source (output valid, output error_limit, input ready);
   modport sink   (input valid, input error_limit, output ready);
endinterface

### rtl/update_frame_receiver_crc_check.sv
// Channel  Direction  Carries
// req      in         rx_byte, frame_end (one received byte per request)
// rsp      out        status, pkt_index, payload_length, computed_crc,
//                     request_index, accepted_count, final_complete (one per frame)
// csr      in         error_limit write
//
// One request is taken per cycle while the frame queue is not full; the byte-wide
// CRC update in the front end sets that pace. After a frame's last byte is taken,
// its response passes through the frame queue, then the response register behind
// the counter update. The frame queue (QUEUE_DEPTH entries) lets bytes keep flowing
// while a response waits; req stalls only when the queue is full.
// Reset is synchronous; no clearing pass.
module update_frame_receiver_crc_check #(
   parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF,
   parameter int QUEUE_DEPTH = ufr_pkg::QUEUE_DEPTH_DEF,
   parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic      clock,
   input  logic      reset,
   ufr_req_if.sink   req_if,
   ufr_rsp_if.source rsp_if,
   ufr_csr_if.sink   csr_if
);

   localparam int QW = $bits(ufr_pkg::frame_info_type) + LEN_W;

   logic                    push, pop, full, not_empty;
   ufr_pkg::frame_info_type push_info, head_info;
   logic [LEN_W-1:0]        push_len, head_len;
   logic [QW-1:0]           head_data;

   // byte intake and frame classification
   ufr_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .LEN_W       (LEN_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (full),
      .q_push (push),
      .q_info (push_info),
      .q_len  (push_len)
   );

   // frame queue
   ufr_queue #(
      .DEPTH (QUEUE_DEPTH),
      .W     (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_info, push_len}),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_data (head_data)
   );

   assign head_info = head_data[QW-1:LEN_W];
   assign head_len  = head_data[LEN_W-1:0];

   // counters and response
   ufr_back #(
      .LEN_W (LEN_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (not_empty),
      .q_info  (head_info),
      .q_len   (head_len),
      .q_pop   (pop),
      .csr_if  (csr_if),
      .rsp_if  (rsp_if)
   );

endmodule

### rtl/ufr_front.sv
module ufr_front #(
   parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF,
   parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   ufr_req_if.sink                 req_if,
   input  logic                    q_full,
   output logic                    q_push,
   output ufr_pkg::frame_info_type q_info,
   output logic [LEN_W-1:0]        q_len
);

   localparam int HB    = ufr_pkg::HEADER_BYTES;
   localparam int CNT_W = $clog2(HB + MAX_PAYLOAD + 1);
   localparam int IDX_W = $clog2(HB);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(HB + MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] CNT_HDR   = CNT_W'(HB);

   logic [CNT_W-1:0] cnt_ff, cnt_in, n_val;
   logic [15:0]      crc_ff, crc_in, crc_step, crc_now;
   logic [7:0]       hdr_ff [HB];
   logic [7:0]       hv     [HB];
   logic [15:0]      stated_len, len_h;
   logic             accept, store_en, in_payload;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign q_push       = accept && req_if.frame_end;

   // byte position and payload window
   assign store_en   = cnt_ff < CNT_LIMIT;
   assign stated_len = {hdr_ff[10], hdr_ff[9]};
   assign in_payload = store_en && (cnt_ff >= CNT_HDR)
                       && (17'(cnt_ff - CNT_HDR) < 17'(stated_len));
   assign crc_step   = ufr_pkg::crc_byte(crc_ff, req_if.rx_byte);
   assign crc_now    = in_payload ? crc_step : crc_ff;
   assign n_val      = store_en ? cnt_ff + CNT_W'(1) : cnt_ff;

   // header as it stands with the current byte in place
   always_comb begin
      for (int i = 0; i < HB; i++) begin
         hv[i] = (cnt_ff == CNT_W'(i)) ? req_if.rx_byte : hdr_ff[i];
      end
   end

   // frame classification at frame end
   always_comb begin
      q_info = '0;
      q_len  = '0;
      len_h  = {hv[10], hv[9]};
      if (n_val <= CNT_W'(ufr_pkg::SHORT_MAX)) begin
         q_info.status = ufr_pkg::ST_SHORT;
      end else if ({hv[0], hv[1], hv[2], hv[3], hv[4]} != ufr_pkg::HEAD_MARK) begin
         q_info.status = ufr_pkg::ST_BAD_HEADER;
      end else if (n_val >= CNT_W'(ufr_pkg::FINAL_MIN)
                   && {hv[5], hv[6], hv[7]} == ufr_pkg::TAIL_MARK) begin
         q_info.status = ufr_pkg::ST_FINAL;
      end else if (n_val < CNT_HDR) begin
         q_info.status = ufr_pkg::ST_SHORT;
      end else begin
         q_info.pkt_index = {hv[8], hv[7]};
         q_info.crc       = crc_now;
         if (17'(len_h) > 17'(MAX_PAYLOAD)) begin
            q_len         = LEN_W'(MAX_PAYLOAD);
            q_info.status = ufr_pkg::ST_TOO_LONG;
         end else begin
            q_len = LEN_W'(len_h);
            if (17'(n_val) < 17'(CNT_HDR) + 17'(len_h)) begin
               q_info.status = ufr_pkg::ST_SHORT;
            end else if ({hv[6], hv[5]} == crc_now) begin
               q_info.status = ufr_pkg::ST_OK;
            end else begin
               q_info.status = ufr_pkg::ST_CRC_BAD;
            end
         end
      end
   end

   // next count and CRC
   always_comb begin
      cnt_in = cnt_ff;
      crc_in = crc_ff;
      if (accept) begin
         if (req_if.frame_end) begin
            cnt_in = '0;
            crc_in = ufr_pkg::CRC_INIT;
         end else if (store_en) begin
            cnt_in = cnt_ff + CNT_W'(1);
            crc_in = crc_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         crc_ff <= ufr_pkg::CRC_INIT;
      end else begin
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
      end
   end

   // header byte store, no reset
   always_ff @(posedge clock) begin
      if (accept && cnt_ff < CNT_HDR) begin
         hdr_ff[cnt_ff[IDX_W-1:0]] <= req_if.rx_byte;
      end
   end

endmodule

### rtl/ufr_queue.sv
module ufr_queue #(
   parameter int DEPTH = ufr_pkg::QUEUE_DEPTH_DEF,
   parameter int W     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output logic [W-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [W-1:0]     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == CNT_W'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head_data = slot_ff[rd_ff];

   // pointer and fill level
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/ufr_back.sv
`include "update_frame_receiver_crc_check_macros.svh"

module ufr_back #(
   parameter int LEN_W = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  ufr_pkg::frame_info_type q_info,
   input  logic [LEN_W-1:0]        q_len,
   output logic                    q_pop,
   ufr_csr_if.sink                 csr_if,
   ufr_rsp_if.source               rsp_if
);

   logic [15:0] req_ff, req_in, good_ff, good_in;
   logic [3:0]  bad_ff, bad_in, lim_ff;
   logic        vld_ff, vld_in;

   ufr_pkg::status_type st_ff;
   logic [15:0]         idx_ff, crc_ff, req_out_ff, good_out_ff;
   logic [LEN_W-1:0]    len_ff;
   logic                fin_ff;

   // take a frame when the response register is free or being drained
   assign q_pop = q_valid && (!vld_ff || rsp_if.ready);

   // counter updates
   always_comb begin
      req_in  = req_ff;
      good_in = good_ff;
      bad_in  = bad_ff;
      if (q_pop) begin
         case (q_info.status)
            ufr_pkg::ST_OK: begin
               req_in  = q_info.pkt_index + 16'd1;
               good_in = good_ff + 16'd1;
               bad_in  = '0;
            end
            ufr_pkg::ST_FINAL: begin
            end
            default: begin
               if (bad_ff >= lim_ff) begin
                  bad_in = lim_ff;
                  req_in = '0;
               end else begin
                  bad_in = bad_ff + 4'd1;
               end
            end
         endcase
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (q_pop) begin
         vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         vld_in = 1'b0;
      end
   end

   // control state and limit register
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff  <= '0;
         good_ff <= '0;
         bad_ff  <= '0;
         vld_ff  <= 1'b0;
         lim_ff  <= ufr_pkg::ERR_LIMIT_RST;
      end else begin
         req_ff  <= req_in;
         good_ff <= good_in;
         bad_ff  <= bad_in;
         vld_ff  <= vld_in;
         if (csr_if.valid && csr_if.ready) begin
            lim_ff <= csr_if.error_limit;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         st_ff       <= q_info.status;
         idx_ff      <= q_info.pkt_index;
         crc_ff      <= q_info.crc;
         len_ff      <= q_len;
         req_out_ff  <= req_in;
         good_out_ff <= good_in;
         fin_ff      <= (q_info.status == ufr_pkg::ST_FINAL) && (req_ff == good_ff);
      end
   end

   assign rsp_if.valid          = vld_ff;
   assign rsp_if.status         = st_ff;
   assign rsp_if.pkt_index      = idx_ff;
   assign rsp_if.payload_length = len_ff;
   assign rsp_if.computed_crc   = crc_ff;
   assign rsp_if.request_index  = req_out_ff;
   assign rsp_if.accepted_count = good_out_ff;
   assign rsp_if.final_complete = fin_ff;

   // checks
   `UFR_ASSERT_NEXT(a_ok_clears_bad, clock, reset,
                    q_pop && q_info.status == ufr_pkg::ST_OK, bad_ff == 4'd0,
                    "accepted frame left error count set")
   `UFR_ASSERT_NEXT(a_ok_counts, clock, reset,
                    q_pop && q_info.status == ufr_pkg::ST_OK,
                    good_ff == $past(good_ff) + 16'd1, "accepted count did not advance")
   `UFR_ASSERT_SAME(a_fin_only_final, clock, reset, vld_ff && fin_ff,
                    st_ff == ufr_pkg::ST_FINAL, "final flag on a non-final frame")
   `UFR_ASSERT_NEXT(a_pop_shows, clock, reset, q_pop,
                    vld_ff && rsp_if.accepted_count == good_ff, "response not loaded after pop")

endmodule

### test/update_frame_receiver_crc_check_tb.sv
module update_frame_receiver_crc_check_tb;

   localparam int PAYLOAD_MAX = 1024;
   localparam int HDR_LEN     = 11;
   localparam int HOLD_CYCLES = 80;

   // receiver ready patterns
   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_ONE_IN_FOUR,
      RX_RARE_STALL
   } rx_pattern_type;

   // one predicted response
   typedef struct {
      ufr_pkg::status_type status;
      logic [15:0] pkt_index;
      logic [10:0] payload_length;
      logic [15:0] computed_crc;
      logic [15:0] request_index;
      logic [15:0] accepted_count;
      logic        final_complete;
   } frame_verdict_type;

   logic clock;
   logic reset;

   ufr_req_if             req_ch ();
   ufr_rsp_if #(.LEN_W(11)) rsp_ch ();
   ufr_csr_if             csr_ch ();

   update_frame_receiver_crc_check dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // receiver state as predicted
   logic [7:0]  hdr_q [0:HDR_LEN-1];
   int unsigned byte_cnt;
   logic [15:0] crc_run;
   logic [15:0] next_req;
   logic [15:0] good_cnt;
   logic [3:0]  bad_run;
   logic [3:0]  err_limit;

   frame_verdict_type expected_verdicts [$];
   logic [7:0]        frame_buf [$];

   int unsigned fail_count;
   int unsigned bytes_sent;
   int unsigned frames_sent;
   int unsigned responses_checked;
   int unsigned burst_left;
   bit          sender_gaps;
   bit          hold_request;
   rx_pattern_type rx_mode;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall time limit
   initial begin
      #8000000;
      $display("tb: failure");
      $finish;
   end

   // CRC-16/Modbus, one byte, bit-serial
   function automatic logic [15:0] crc16_modbus(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (r[0] ? ufr_pkg::CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void clear_receiver_state();
      foreach (hdr_q[i]) hdr_q[i] = 8'h00;
      byte_cnt  = 0;
      crc_run   = ufr_pkg::CRC_INIT;
      next_req  = 16'h0000;
      good_cnt  = 16'h0000;
      bad_run   = 4'h0;
      err_limit = ufr_pkg::ERR_LIMIT_RST;
   endfunction

   // update the predicted state with one accepted byte; queue a verdict at frame end
   function automatic void take_frame_byte(logic [7:0] b, logic fe);
      frame_verdict_type v;
      int unsigned n;
      int unsigned stated;
      if (byte_cnt < HDR_LEN + PAYLOAD_MAX) begin
         if (byte_cnt < HDR_LEN) begin
            hdr_q[byte_cnt] = b;
         end else if (byte_cnt - HDR_LEN < int'({hdr_q[10], hdr_q[9]})) begin
            crc_run = crc16_modbus(crc_run, b);
         end
         byte_cnt++;
      end
      if (!fe) return;

      v.status         = ufr_pkg::ST_OK;
      v.pkt_index      = 16'h0000;
      v.payload_length = 11'h000;
      v.computed_crc   = 16'h0000;
      v.final_complete = 1'b0;
      n = byte_cnt;
      if (n <= ufr_pkg::SHORT_MAX) begin
         v.status = ufr_pkg::ST_SHORT;
      end else if ({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3], hdr_q[4]} != ufr_pkg::HEAD_MARK) begin
         v.status = ufr_pkg::ST_BAD_HEADER;
      end else if (n >= ufr_pkg::FINAL_MIN
                   && {hdr_q[5], hdr_q[6], hdr_q[7]} == ufr_pkg::TAIL_MARK) begin
         v.status         = ufr_pkg::ST_FINAL;
         v.final_complete = (next_req == good_cnt);
      end else if (n < HDR_LEN) begin
         v.status = ufr_pkg::ST_SHORT;
      end else begin
         stated           = {hdr_q[10], hdr_q[9]};
         v.pkt_index      = {hdr_q[8], hdr_q[7]};
         v.computed_crc   = crc_run;
         v.payload_length = (stated > PAYLOAD_MAX) ? 11'(PAYLOAD_MAX) : 11'(stated);
         if (stated > PAYLOAD_MAX) begin
            v.status = ufr_pkg::ST_TOO_LONG;
         end else if (n < HDR_LEN + stated) begin
            v.status = ufr_pkg::ST_SHORT;
         end else if ({hdr_q[6], hdr_q[5]} == crc_run) begin
            v.status = ufr_pkg::ST_OK;
         end else begin
            v.status = ufr_pkg::ST_CRC_BAD;
         end
      end

      // counters
      if (v.status == ufr_pkg::ST_OK) begin
         next_req = v.pkt_index + 16'd1;
         good_cnt = good_cnt + 16'd1;
         bad_run  = 4'h0;
      end else if (v.status != ufr_pkg::ST_FINAL) begin
         if (bad_run >= err_limit) begin
            bad_run  = err_limit;
            next_req = 16'h0000;
         end else begin
            bad_run = bad_run + 4'd1;
         end
      end
      byte_cnt = 0;
      crc_run  = ufr_pkg::CRC_INIT;

      v.request_index  = next_req;
      v.accepted_count = good_cnt;
      expected_verdicts.push_back(v);
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_response();
      frame_verdict_type v;
      if (expected_verdicts.size() == 0) begin
         $error("response with nothing expected, status %0d", rsp_ch.status);
         fail_count++;
         return;
      end
      v = expected_verdicts.pop_front();
      check_field("status", 16'(v.status), 16'(rsp_ch.status));
      check_field("pkt_index", v.pkt_index, rsp_ch.pkt_index);
      check_field("payload_length", 16'(v.payload_length), 16'(rsp_ch.payload_length));
      check_field("computed_crc", v.computed_crc, rsp_ch.computed_crc);
      check_field("request_index", v.request_index, rsp_ch.request_index);
      check_field("accepted_count", v.accepted_count, rsp_ch.accepted_count);
      check_field("final_complete", 16'(v.final_complete), 16'(rsp_ch.final_complete));
      responses_checked++;
   endfunction

   // response side: check on each handshake, then choose next ready
   initial begin
      int unsigned hold_left;
      int unsigned rx_tick;
      logic        rdy;
      hold_left = 0;
      rx_tick   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_response();
         rx_tick++;
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         case (rx_mode)
            RX_ALWAYS:      rdy = 1'b1;
            RX_RANDOM:      rdy = $urandom_range(0, 1);
            RX_ONE_IN_FOUR: rdy = (rx_tick % 4 == 0);
            default:        rdy = ($urandom_range(0, 7) != 0);
         endcase
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end
         rsp_ch.ready <= reset ? 1'b0 : rdy;
      end
   end

   // offer one byte, with bursty gaps when enabled
   task automatic send_byte(logic [7:0] b, logic fe);
      if (sender_gaps && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.rx_byte   <= b;
      req_ch.frame_end <= fe;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      take_frame_byte(b, fe);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
   endtask

   // sender pauses until every response is in
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_error_limit(logic [3:0] lim);
      settle();
      csr_ch.valid       <= 1'b1;
      csr_ch.error_limit <= lim;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      err_limit = lim;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic void push_start();
      for (int k = 4; k >= 0; k--) frame_buf.push_back(ufr_pkg::HEAD_MARK[8*k +: 8]);
   endfunction

   // data packet; fill < 0 gives random payload
   function automatic void build_packet(logic [15:0] idx, int unsigned stated,
                                        int unsigned sent, bit crc_ok, int fill = -1);
      logic [7:0]  pay [$];
      logic [7:0]  pb;
      logic [15:0] c;
      int unsigned covered;
      c = ufr_pkg::CRC_INIT;
      covered = (stated < sent) ? stated : sent;
      if (covered > PAYLOAD_MAX) covered = PAYLOAD_MAX;
      for (int unsigned i = 0; i < sent; i++) begin
         pb = (fill < 0) ? 8'($urandom) : 8'(fill);
         pay.push_back(pb);
         if (i < covered) c = crc16_modbus(c, pb);
      end
      if (!crc_ok) c = c ^ 16'($urandom_range(1, 16'hFFFF));
      frame_buf = {};
      push_start();
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
      frame_buf.push_back(idx[7:0]);
      frame_buf.push_back(idx[15:8]);
      frame_buf.push_back(8'(stated));
      frame_buf.push_back(8'(stated >> 8));
      foreach (pay[i]) frame_buf.push_back(pay[i]);
   endfunction

   function automatic void build_final(int unsigned extra);
      frame_buf = {};
      push_start();
      for (int k = 2; k >= 0; k--) frame_buf.push_back(ufr_pkg::TAIL_MARK[8*k +: 8]);
      repeat (extra) frame_buf.push_back(8'($urandom));
   endfunction

   // arbitrary bytes, optionally behind a valid start mark
   function automatic void build_raw(int unsigned n, bit with_start);
      frame_buf = {};
      if (with_start) push_start();
      repeat (n) frame_buf.push_back(8'($urandom));
   endfunction

   // header cases, status codes, payload extremes, index wrap
   task automatic test_directed_frames();
      sender_gaps = 1'b0;
      rx_mode     = RX_ALWAYS;
      build_raw(1, 0);                 send_frame();
      build_raw(0, 1);                 send_frame();
      build_raw(1, 1);
      frame_buf[4] = 8'hFF;            send_frame();
      build_final(0);                  send_frame();
      build_raw(2, 1);                 send_frame();
      build_raw(5, 1);
      frame_buf[5] = 8'h00;            send_frame();
      build_packet(16'd0, 0, 0, 1);    send_frame();
      build_packet(16'd1, 4, 4, 1, 8'hFF); send_frame();
      build_packet(16'd2, 3, 3, 1, 8'h00); send_frame();
      build_packet(16'd3, 3, 3, 0);    send_frame();
      build_packet(16'd4, 8, 3, 1);    send_frame();
      build_packet(16'd5, 1025, 2, 1); send_frame();
      build_packet(16'd6, 16'hFFFF, 0, 1); send_frame();
      build_packet(16'd7, 2, 6, 1);    send_frame();
      build_packet(16'hFFFF, 1, 1, 1); send_frame();
      build_final(3);                  send_frame();
   endtask

   // run of bad frames against low, zero and high limits
   task automatic test_error_limit();
      set_error_limit(4'd1);
      build_packet(16'd7, 2, 2, 1);    send_frame();
      repeat (3) begin build_raw(1, 0); send_frame(); end
      set_error_limit(4'd0);
      build_packet(16'd3, 1, 1, 1);    send_frame();
      build_raw(1, 0);                 send_frame();
      set_error_limit(4'd15);
      build_packet(16'd9, 0, 0, 1);    send_frame();
      repeat (17) begin build_raw(1, 0); send_frame(); end
      // limit lowered below the current run of bad frames
      set_error_limit(4'd5);
      build_packet(16'd20, 0, 0, 1);   send_frame();
      build_raw(1, 0);                 send_frame();
   endtask

   // full buffer, with bytes past it that must be ignored
   task automatic test_long_frame();
      settle();
      sender_gaps = 1'b1;
      rx_mode     = RX_RANDOM;
      build_packet(16'h1234, PAYLOAD_MAX, PAYLOAD_MAX + 6, 1);
      send_frame();
   endtask

   // long receiver stall while the sender keeps going, then a full pause and bad frames to a sparsely ready receiver
   task automatic test_backpressure();
      settle();
      sender_gaps  = 1'b0;
      rx_mode      = RX_ALWAYS;
      hold_request = 1'b1;
      repeat (8) begin
         build_packet(next_req, 0, 0, 1);
         send_frame();
      end
      settle();
      rx_mode = RX_ONE_IN_FOUR;
      repeat (4) begin build_raw(1, 0); send_frame(); end
      settle();
   endtask

   function automatic int unsigned pick_len();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
   endfunction

   task automatic random_frame();
      int unsigned kind;
      int unsigned stated;
      logic [15:0] idx;
      kind   = $urandom_range(0, 99);
      stated = pick_len();
      idx    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : next_req;
      if (kind < 60) begin
         build_packet(idx, stated, stated, 1);
      end else if (kind < 68) begin
         build_packet(idx, stated, stated, 0);
      end else if (kind < 74) begin
         build_packet(idx, stated, stated + $urandom_range(1, 4), $urandom_range(0, 1));
      end else if (kind < 80) begin
         stated = stated + 1;
         build_packet(idx, stated, $urandom_range(0, stated - 1), 1);
      end else if (kind < 83) begin
         build_packet(idx, $urandom_range(PAYLOAD_MAX + 1, 16'hFFFF), $urandom_range(0, 6), 1);
      end else if (kind < 90) begin
         build_final($urandom_range(0, 4));
      end else begin
         build_raw($urandom_range(1, 12), $urandom_range(0, 1));
      end
      send_frame();
   endtask

   // mostly well-formed traffic in phases of random limit and idling
   task automatic test_random();
      int unsigned start_bytes;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 300) begin
         set_error_limit(4'($urandom_range(1, 15)));
         sender_gaps = $urandom_range(0, 1);
         rx_mode     = rx_pattern_type'($urandom_range(0, 3));
         repeat ($urandom_range(6, 10)) random_frame();
      end
   endtask

   task automatic finish_run();
      int unsigned waited;
      req_ch.valid <= 1'b0;
      waited = 0;
      while (expected_verdicts.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_verdicts.size() != 0) begin
         $error("%0d responses never arrived", expected_verdicts.size());
         fail_count++;
      end
      repeat (8) @(posedge clock);
      $display("tb: %0d bytes in %0d frames, %0d responses checked", bytes_sent, frames_sent,
               responses_checked);
      $display("tb: covered all status codes, limits 0 to 15, full buffer and back-pressure");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   endtask

   // test sequence
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.rx_byte     = 8'h00;
      req_ch.frame_end   = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.error_limit = 4'h0;
      hold_request       = 1'b0;
      sender_gaps        = 1'b0;
      rx_mode            = RX_ALWAYS;
      burst_left         = 0;
      fail_count         = 0;
      bytes_sent         = 0;
      frames_sent        = 0;
      responses_checked  = 0;
      clear_receiver_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_error_limit();
      test_long_frame();
      test_backpressure();
      test_random();
      finish_run();
   end

endmodule
